// ===== hdl/audio_echo_delay_mix_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the echo delay mixer
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_ECHO_DELAY_MIX_ASSERT_SVH
`define AUDIO_ECHO_DELAY_MIX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AEDM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AEDM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// The expression must hold at every clock edge outside reset.
`define AEDM_ASSERT_ALW(label, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cons)) \
    else $error(msg);

`endif

// ===== hdl/aedm_pkg.sv =====
// ----------------------------------------------------------------------------
// Echo delay mixer package
// Widths, register indexes, microcode format and arithmetic helpers.
// ----------------------------------------------------------------------------
package aedm_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DLEN_W     = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 4;

  localparam logic [GAIN_W-1:0] Q15_ONE = 16'd32768;

  localparam logic [DLEN_W-1:0]   RST_DELAY_LENGTH = 15'd4800;
  localparam logic [GAIN_W-1:0]   RST_ATTENUATION  = 16'd16384;
  localparam logic [GAIN_W-1:0]   RST_DRY_FRACTION = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH,
    REG_ATTENUATION,
    REG_DRY_FRACTION,
    REG_ENABLE
  } aedm_reg_e;

  typedef enum logic [STEP_W-1:0] {
    STEP_IDLE,
    STEP_READ,
    STEP_WRITE,
    STEP_MUL_ATT,
    STEP_MUL_DRY,
    STEP_MUL_WET,
    STEP_ADD,
    STEP_SAT,
    STEP_OUT
  } aedm_step_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_JUMP,
    BR_WAIT_IN,
    BR_WAIT_OUT
  } aedm_br_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_ATT,
    MUL_DRY,
    MUL_WET
  } aedm_mul_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_ATT,
    ACC_DRY,
    ACC_ADD,
    ACC_SAT
  } aedm_acc_e;

  typedef struct packed {
    logic       in_rdy;
    logic       rd_en;
    logic       wr_en;
    aedm_mul_e  mul_sel;
    aedm_acc_e  acc_op;
    logic       out_ld;
    aedm_br_e   br;
    aedm_step_e target;
  } aedm_uop_t;

  function automatic aedm_uop_t aedm_ucode(input aedm_step_e step);
    aedm_uop_t u;
    u = '{in_rdy: 1'b0, rd_en: 1'b0, wr_en: 1'b0, mul_sel: MUL_NONE,
          acc_op: ACC_NONE, out_ld: 1'b0, br: BR_NEXT, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        u.in_rdy = 1'b1;
        u.br     = BR_WAIT_IN;
        u.target = STEP_OUT;
      end
      STEP_READ:    u.rd_en = 1'b1;
      STEP_WRITE:   u.wr_en = 1'b1;
      STEP_MUL_ATT: u.mul_sel = MUL_ATT;
      STEP_MUL_DRY: begin
        u.mul_sel = MUL_DRY;
        u.acc_op  = ACC_ATT;
      end
      STEP_MUL_WET: begin
        u.mul_sel = MUL_WET;
        u.acc_op  = ACC_DRY;
      end
      STEP_ADD:     u.acc_op = ACC_ADD;
      STEP_SAT:     u.acc_op = ACC_SAT;
      STEP_OUT: begin
        u.out_ld = 1'b1;
        u.br     = BR_WAIT_OUT;
        u.target = STEP_IDLE;
      end
      default: begin
        u.br     = BR_JUMP;
        u.target = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

  // Divides a Q15 product by 32768, rounding toward zero.
  function automatic logic signed [16:0] aedm_trunc_q15(input logic signed [31:0] p);
    logic signed [31:0] adj;
    adj = p + (p[31] ? 32'sd32767 : 32'sd0);
    return adj[31:15];
  endfunction

endpackage

// ===== hdl/aedm_in_if.sv =====
// ----------------------------------------------------------------------------
// Echo delay mixer input channel
// Valid/ready channel carrying one input audio sample per transaction.
// ----------------------------------------------------------------------------
interface aedm_in_if
  import aedm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== hdl/aedm_out_if.sv =====
// ----------------------------------------------------------------------------
// Echo delay mixer output channel
// Valid/ready channel carrying one mixed audio sample per transaction.
// ----------------------------------------------------------------------------
interface aedm_out_if
  import aedm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== hdl/aedm_ram.sv =====
// ----------------------------------------------------------------------------
// Echo delay mixer RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module aedm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/audio_echo_delay_mix.sv =====
// ----------------------------------------------------------------------------
// Audio echo delay mixer
// Feed-forward echo on signed Q15 samples. With the echo enabled, a sample's
// transaction is followed by the steps of the microprogram: one delay store
// read, one write, three passes through a single shared 17x17 multiplier, an
// add, a saturation and the output load. The next sample is taken only once
// the sequencer has returned to its idle step. With the echo disabled, the
// sequencer goes from the idle step straight to the output step. A finished
// result waits in an output register, so the next sample is taken while the
// previous result is still pending; the sequencer holds in its output step
// only while that register is still full. The delay store needs no clearing
// pass: entries not yet written since reset read as zero through a fill
// tracker.
// ----------------------------------------------------------------------------
`include "audio_echo_delay_mix_assert.svh"

module audio_echo_delay_mix
  import aedm_pkg::*;
#(
  parameter int unsigned MAX_DELAY = 16384
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aedm_in_if.sink               in_i,
  aedm_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_DELAY);
  localparam int unsigned CW = (AW + 1 > DLEN_W) ? AW + 1 : DLEN_W;
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_DELAY);
  localparam logic [AW:0]   MAX_WP = (AW + 1)'(MAX_DELAY);

  logic [DLEN_W-1:0] delay_length_q;
  logic [GAIN_W-1:0] attenuation_q;
  logic [GAIN_W-1:0] dry_fraction_q;
  logic              enable_q;

  aedm_step_e step_q, step_d;
  aedm_uop_t  uop;

  logic [AW-1:0] wp_q, wp_d;
  logic          wrapped_q, wrapped_d;
  logic          rdv_q;

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [SAMPLE_W-1:0] dly_q;
  logic signed [16:0]         att_q;
  logic signed [31:0]         prod_q;
  logic signed [32:0]         sum_q;
  logic signed [SAMPLE_W-1:0] y_q;

  logic                       out_vld_q, out_vld_d;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  logic          in_acc;
  logic          out_free;
  logic [CW-1:0] d_ext, d_eff, wp_ext, rd_full;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   wp_inc;
  logic [SAMPLE_W-1:0] rdata;

  logic [GAIN_W-1:0]          a_eff, dry_eff;
  logic signed [16:0]         op_a, op_b;
  logic signed [33:0]         prod;
  logic signed [16:0]         q15_tr;
  logic signed [32:0]         sum_adj;
  logic signed [17:0]         sum_tr;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign uop      = aedm_ucode(step_q);
  assign in_acc   = in_i.valid && uop.in_rdy;
  assign out_free = !out_vld_q || out_o.ready;
  assign q15_tr   = aedm_trunc_q15(prod_q);

  assign in_i.ready       = uop.in_rdy;
  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q <= RST_DELAY_LENGTH;
      attenuation_q  <= RST_ATTENUATION;
      dry_fraction_q <= RST_DRY_FRACTION;
      enable_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (aedm_reg_e'(cfg_idx_i))
        REG_DELAY_LENGTH: delay_length_q <= cfg_data_i[DLEN_W-1:0];
        REG_ATTENUATION:  attenuation_q  <= cfg_data_i[GAIN_W-1:0];
        REG_DRY_FRACTION: dry_fraction_q <= cfg_data_i[GAIN_W-1:0];
        REG_ENABLE:       enable_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step_d = step_q;
    case (uop.br)
      BR_NEXT:  step_d = aedm_step_e'(STEP_W'(step_q) + STEP_W'(1));
      BR_JUMP:  step_d = uop.target;
      BR_WAIT_IN: begin
        if (in_acc) begin
          step_d = enable_q ? aedm_step_e'(STEP_W'(step_q) + STEP_W'(1)) : uop.target;
        end
      end
      BR_WAIT_OUT: begin
        if (out_free) begin
          step_d = uop.target;
        end
      end
      default: step_d = STEP_IDLE;
    endcase
  end

  always_comb begin
    d_ext = CW'(delay_length_q);
    if (d_ext == '0) begin
      d_eff = CW'(1);
    end else if (d_ext > MAX_C) begin
      d_eff = MAX_C;
    end else begin
      d_eff = d_ext;
    end
    wp_ext  = CW'(wp_q);
    rd_full = (wp_ext >= d_eff) ? wp_ext - d_eff : wp_ext + MAX_C - d_eff;
    rd_addr = rd_full[AW-1:0];

    wp_inc    = (AW + 1)'(wp_q) + (AW + 1)'(1);
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (uop.wr_en) begin
      if (wp_inc >= MAX_WP) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_inc[AW-1:0];
      end
    end
  end

  aedm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (uop.wr_en),
    .waddr_i (wp_q),
    .wdata_i (x_q),
    .re_i    (uop.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    a_eff   = (attenuation_q > Q15_ONE) ? Q15_ONE : attenuation_q;
    dry_eff = (dry_fraction_q > Q15_ONE) ? Q15_ONE : dry_fraction_q;
    op_a    = '0;
    op_b    = '0;
    case (uop.mul_sel)
      MUL_ATT: begin
        op_a = {dly_q[SAMPLE_W-1], dly_q};
        op_b = {1'b0, a_eff};
      end
      MUL_DRY: begin
        op_a = {x_q[SAMPLE_W-1], x_q};
        op_b = {1'b0, dry_eff};
      end
      MUL_WET: begin
        op_a = att_q;
        op_b = {1'b0, Q15_ONE} - {1'b0, dry_eff};
      end
      default: ;
    endcase
    prod = op_a * op_b;

    sum_adj = sum_q + (sum_q[32] ? 33'sd32767 : 33'sd0);
    sum_tr  = sum_adj[32:15];
    if (sum_tr > 18'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (sum_tr < -18'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = sum_tr[15:0];
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (uop.out_ld && out_free) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_IDLE;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_i.sample_in;
      y_q <= in_i.sample_in;
    end
    if (uop.rd_en) begin
      rdv_q <= wrapped_q || (rd_addr < wp_q);
    end
    if (uop.wr_en) begin
      dly_q <= rdv_q ? rdata : '0;
    end
    if (uop.mul_sel != MUL_NONE) begin
      prod_q <= prod[31:0];
    end
    case (uop.acc_op)
      ACC_ATT: att_q <= q15_tr;
      ACC_DRY: sum_q <= {q15_tr[16], q15_tr, 15'd0};
      ACC_ADD: sum_q <= sum_q + {prod_q[31], prod_q};
      ACC_SAT: y_q   <= y_sat;
      default: ;
    endcase
    if (uop.out_ld && out_free) begin
      out_sample_q <= y_q;
    end
  end

  `AEDM_ASSERT_IMP(a_write_only_enabled, uop.wr_en, enable_q, "store written while disabled")
  `AEDM_ASSERT_NXT(a_bypass_to_out, in_acc && !enable_q, step_q == STEP_OUT, "bypass misrouted")
  `AEDM_ASSERT_IMP(a_read_not_write, uop.rd_en && (d_eff != MAX_C), rd_addr != wp_q, "read hits write")
  `AEDM_ASSERT_ALW(a_wp_in_range, (AW + 1)'(wp_q) < MAX_WP, "write position out of range")

endmodule
